[rtl/scanline_object_renderer_macros.svh]
// Assertion macros shared by the renderer RTL.
`ifndef SCANLINE_OBJECT_RENDERER_MACROS_SVH
`define SCANLINE_OBJECT_RENDERER_MACROS_SVH
`define SOR_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define SOR_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[rtl/sor_pkg.sv]
// ----------------------------------------------------------------------------
// sor_pkg
// Shared constants, register addresses and the palette for the renderer.
// ----------------------------------------------------------------------------
package sor_pkg;
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_FIRE  = 2'd3;

    localparam logic [7:0] R_VBLANK = 8'h01;
    localparam logic [7:0] R_WSYNC  = 8'h02;
    localparam logic [7:0] R_NUSIZ0 = 8'h04;
    localparam logic [7:0] R_NUSIZ1 = 8'h05;
    localparam logic [7:0] R_COLUP0 = 8'h06;
    localparam logic [7:0] R_COLUP1 = 8'h07;
    localparam logic [7:0] R_COLUPF = 8'h08;
    localparam logic [7:0] R_COLUBK = 8'h09;
    localparam logic [7:0] R_CTRLPF = 8'h0A;
    localparam logic [7:0] R_REFP0  = 8'h0B;
    localparam logic [7:0] R_REFP1  = 8'h0C;
    localparam logic [7:0] R_PF0    = 8'h0D;
    localparam logic [7:0] R_PF1    = 8'h0E;
    localparam logic [7:0] R_PF2    = 8'h0F;
    localparam logic [7:0] R_RESP0  = 8'h10;
    localparam logic [7:0] R_RESP1  = 8'h11;
    localparam logic [7:0] R_RESM0  = 8'h12;
    localparam logic [7:0] R_RESM1  = 8'h13;
    localparam logic [7:0] R_RESBL  = 8'h14;
    localparam logic [7:0] R_GRP0   = 8'h1B;
    localparam logic [7:0] R_GRP1   = 8'h1C;
    localparam logic [7:0] R_ENAM0  = 8'h1D;
    localparam logic [7:0] R_ENAM1  = 8'h1E;
    localparam logic [7:0] R_ENABL  = 8'h1F;
    localparam logic [7:0] R_HMP0   = 8'h20;
    localparam logic [7:0] R_HMP1   = 8'h21;
    localparam logic [7:0] R_HMM0   = 8'h22;
    localparam logic [7:0] R_HMM1   = 8'h23;
    localparam logic [7:0] R_HMBL   = 8'h24;
    localparam logic [7:0] R_HMOVE  = 8'h2A;
    localparam logic [7:0] R_HMCLR  = 8'h2B;
    localparam logic [7:0] R_CXCLR  = 8'h2C;
    localparam logic [7:0] R_CXM0P  = 8'h30;
    localparam logic [7:0] R_CXM1P  = 8'h31;
    localparam logic [7:0] R_CXP0FB = 8'h32;
    localparam logic [7:0] R_CXP1FB = 8'h33;
    localparam logic [7:0] R_CXM0FB = 8'h34;
    localparam logic [7:0] R_CXM1FB = 8'h35;
    localparam logic [7:0] R_CXBLPF = 8'h36;
    localparam logic [7:0] R_CXPPMM = 8'h37;
    localparam logic [7:0] R_INPT4  = 8'h3C;
    localparam logic [7:0] R_LAST_IN = 8'h3D;

    localparam logic [7:0] HBLANK_DOTS  = 8'd68;
    localparam logic [7:0] VISIBLE_DOTS = 8'd160;

    // Colour-relevant registers snapshot handed to the pixel renderer.
    typedef struct packed {
        logic [7:0] nusiz0, nusiz1, colup0, colup1, colupf, colubk, ctrlpf;
        logic [7:0] refp0, refp1, pf0, pf1, pf2, grp0, grp1, enam0, enam1, enabl;
        logic [7:0] pos_p0, pos_p1, pos_m0, pos_m1, pos_bl;
    } sor_vid_t;

    typedef struct packed {
        logic [23:0] rgb;
        logic [14:0] hits;
    } sor_pix_t;

    localparam logic [23:0] COLOR_ROM [128] = '{
        24'h000000,24'h404040,24'h6c6c6c,24'h909090,24'hb0b0b0,24'hc8c8c8,24'hdcdcdc,24'hf4f4f4,
        24'h444400,24'h646410,24'h848424,24'ha0a034,24'hb8b840,24'hd0d050,24'he8e85c,24'hfcfc68,
        24'h702800,24'h844414,24'h985c28,24'hac783c,24'hbc8c4c,24'hcca05c,24'hdcb468,24'hecc878,
        24'h841800,24'h983418,24'hac5030,24'hc06848,24'hd0805c,24'he09470,24'heca880,24'hfcbc94,
        24'h880000,24'h9c2020,24'hb03c3c,24'hc05858,24'hd07070,24'he08888,24'heca0a0,24'hfcb4b4,
        24'h78005c,24'h8c2074,24'ha03c88,24'hb0589c,24'hc070b0,24'hd084c0,24'hdc9cd0,24'hecb0e0,
        24'h480078,24'h602090,24'h783ca4,24'h8c58b8,24'ha070cc,24'hb484dc,24'hc49cec,24'hd4b0fc,
        24'h140084,24'h302098,24'h4c3cac,24'h6858c0,24'h7c70d0,24'h9488e0,24'ha8a0ec,24'hbcb4fc,
        24'h000088,24'h1c209c,24'h3840b0,24'h505cc0,24'h6874d0,24'h7c8ce0,24'h90a4ec,24'ha4b8fc,
        24'h00187c,24'h1c3890,24'h3854a8,24'h5070bc,24'h6888cc,24'h7c9cdc,24'h90b4ec,24'ha4c8fc,
        24'h002c5c,24'h1c4c78,24'h386890,24'h5084ac,24'h689cc0,24'h7cb4d4,24'h90cce8,24'ha4e0fc,
        24'h003c2c,24'h1c5c48,24'h387c64,24'h509c80,24'h68b494,24'h7cd0ac,24'h90e4c0,24'ha4fcd4,
        24'h003c00,24'h205c20,24'h407c40,24'h5c9c5c,24'h74b474,24'h8cd08c,24'ha4e4a4,24'hb8fcb8,
        24'h143800,24'h345c1c,24'h507c38,24'h6c9850,24'h84b468,24'h9ccc7c,24'hb4e490,24'hc8fca4,
        24'h2c3000,24'h4c501c,24'h687034,24'h848c4c,24'h9ca864,24'hb4c078,24'hccd488,24'he0ec9c,
        24'h442800,24'h644818,24'h846830,24'ha08444,24'hb89c58,24'hd0b46c,24'he8cc7c,24'hfce08c
    };
endpackage

[rtl/sor_pixel.sv]
// ----------------------------------------------------------------------------
// sor_pixel
// Combinational pixel renderer: object hits, collision bits and colour.
// ----------------------------------------------------------------------------
module sor_pixel import sor_pkg::*; (
    input  sor_vid_t   vid,
    input  logic [7:0] x,
    output sor_pix_t   pix
);
    logic [5:0] col;
    logic [4:0] q;
    logic [2:0] pidx;
    logic       pf, m0, m1, bl, p0, p1;
    logic [7:0] csel;

    function automatic logic pf_fwd(input logic [4:0] c, input logic [7:0] a,
                                    input logic [7:0] b, input logic [7:0] d);
        logic [4:0] t;
        t = 5'd0;
        if (c < 5'd4) return a[3'd4 + c[1:0]];
        if (c < 5'd12) begin
            t = c - 5'd4;
            return b[3'd7 - t[2:0]];
        end
        t = c - 5'd12;
        return d[t[2:0]];
    endfunction

    function automatic logic span(input logic [7:0] en, input logic [1:0] sz,
                                  input logic [7:0] st, input logic [7:0] xx);
        logic [7:0] d;
        d = xx - st;
        return en[1] && (xx >= st) && (d < (8'd1 << sz));
    endfunction

    function automatic logic phit(input logic [7:0] g, input logic [7:0] r,
                                  input logic [7:0] st, input logic [7:0] xx);
        logic [7:0] d;
        logic [2:0] k;
        d = xx - st;
        k = d[2:0] ^ {3{r[3]}};
        return (xx >= st) && (d < 8'd8) && g[3'd7 ^ k];
    endfunction

    always_comb begin
        // Playfield column 0..39, four pixels wide each.
        col = x[7:2];
        q = 5'(col - 6'd20);
        pidx = 3'd0;
        if (col < 6'd20) pf = pf_fwd(col[4:0], vid.pf0, vid.pf1, vid.pf2);
        else if (!vid.ctrlpf[0]) pf = pf_fwd(q, vid.pf0, vid.pf1, vid.pf2);
        else if (q < 5'd8) pf = vid.pf2[3'd7 - q[2:0]];
        else if (q < 5'd16) pf = vid.pf1[q[2:0]];
        else begin
            pidx = 3'd7 - {1'b0, q[1:0]};
            pf = vid.pf0[pidx];
        end
        m0 = span(vid.enam0, vid.nusiz0[5:4], vid.pos_m0, x);
        m1 = span(vid.enam1, vid.nusiz1[5:4], vid.pos_m1, x);
        bl = span(vid.enabl, vid.ctrlpf[5:4], vid.pos_bl, x);
        p0 = phit(vid.grp0, vid.refp0, vid.pos_p0, x);
        p1 = phit(vid.grp1, vid.refp1, vid.pos_p1, x);
        // Bit order: CXM0P 7,6 / CXM1P 7,6 / P0FB / P1FB / M0FB / M1FB / PPMM / BLPF
        pix.hits = {m0 & p1, m0 & p0, m1 & p0, m1 & p1, p0 & pf, p0 & bl,
                    p1 & pf, p1 & bl, m0 & pf, m0 & bl, m1 & pf, m1 & bl,
                    p0 & p1, m0 & m1, bl & pf};
        if (vid.ctrlpf[2]) begin
            priority if (pf | bl) csel = vid.colupf;
            else if (p0 | m0) csel = vid.colup0;
            else if (p1 | m1) csel = vid.colup1;
            else csel = vid.colubk;
        end else begin
            priority if (p0 | m0) csel = vid.colup0;
            else if (p1 | m1) csel = vid.colup1;
            else if (pf | bl) csel = vid.colupf;
            else csel = vid.colubk;
        end
        pix.rgb = COLOR_ROM[csel[7:1]];
    end
endmodule

[rtl/scanline_object_renderer.sv]
// ----------------------------------------------------------------------------
// scanline_object_renderer
// Video chip: bus register file, object positions and one-pixel renderer.
// ----------------------------------------------------------------------------
// Usage: every input transaction on s_ carries one command (bus write, bus
// read, dot tick or fire button). Every command yields exactly one result
// transaction on m_, holding read data, the rendered pixel when the dot was
// visible, the frame-ready pulse and the wsync status.
// The command is worked out by combinational logic and the result is captured
// in the output register on the accepting edge.
// Throughput is one transaction per cycle unless the receiver stalls; s_ready
// is high whenever the output register is empty or being drained in the same cycle.
// When the receiver stalls, the result holds and s_ready falls, so no
// further command changes the state until the result is taken.
// Only bytes that can ever be observed are kept: the video control block
// below the motion registers, the five motion bytes and the fourteen
// collision and input latches. Writes elsewhere store no byte.
// Reset clears all of them, the counters, the positions and the flags.
// The per-dot path is one palette lookup and a handful of short compares.
// ----------------------------------------------------------------------------
`include "scanline_object_renderer_macros.svh"
module scanline_object_renderer import sor_pkg::*; #(
    parameter int DOTS_PER_LINE = 228,
    parameter int VISIBLE_LINES = 192
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [15:0] s_addr,
    input  logic [7:0]  s_wdata,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_rdata,
    output logic        m_pixel_valid,
    output logic [7:0]  m_pixel_x,
    output logic [7:0]  m_pixel_y,
    output logic [23:0] m_pixel_rgb,
    output logic        m_frame_ready,
    output logic        m_wsync_busy
);
    localparam logic [7:0] DPL = 8'(DOTS_PER_LINE);
    localparam logic [8:0] VL  = 9'(VISIBLE_LINES);

    // Video control bytes (addresses below the motion block), motion bytes
    // and the collision / input latches, each indexed by its low address bits.
    logic [7:0] vreg_reg [32];
    logic [7:0] vreg_next [32];
    logic [7:0] hm_reg [5];
    logic [7:0] hm_next [5];
    logic [7:0] lat_reg [14];
    logic [7:0] lat_next [14];
    logic [7:0] dot_reg, dot_next, dotp1;
    logic [8:0] line_reg, line_next;
    logic [7:0] pp0_reg, pp1_reg, pm0_reg, pm1_reg, pbl_reg;
    logic [7:0] pp0_next, pp1_next, pm0_next, pm1_next, pbl_next;
    logic       vbd_reg, vbd_next, ws_reg, ws_next;
    logic       mv_reg;
    logic [7:0] rd_reg, rd_next, px_reg, px_next, py_reg, py_next;
    logic       pv_reg, pv_next, fr_reg, fr_next;
    logic [23:0] rgb_reg, rgb_next;
    logic        take;
    logic [7:0]  a, xpos, rpos;
    sor_vid_t    vid;
    sor_pix_t    pix;

    function automatic logic [7:0] moved(input logic [7:0] p, input logic [7:0] hm);
        logic [8:0] v;
        // p - signed nibble, then wrap into 0..159
        v = {1'b0, p} - {{5{hm[7]}}, hm[7:4]};
        if (v[8]) v = v + 9'd160;
        else if (v >= 9'd160) v = v - 9'd160;
        return v[7:0];
    endfunction

    assign s_ready = !mv_reg || m_ready;
    assign take = s_valid && s_ready;
    assign a = s_addr[7:0];
    assign xpos = dot_reg - HBLANK_DOTS;
    assign rpos = dot_reg - HBLANK_DOTS + 8'd8;
    assign dotp1 = dot_reg + 8'd1;

    always_comb begin
        vid.nusiz0 = vreg_reg[5'(R_NUSIZ0)]; vid.nusiz1 = vreg_reg[5'(R_NUSIZ1)];
        vid.colup0 = vreg_reg[5'(R_COLUP0)]; vid.colup1 = vreg_reg[5'(R_COLUP1)];
        vid.colupf = vreg_reg[5'(R_COLUPF)]; vid.colubk = vreg_reg[5'(R_COLUBK)];
        vid.ctrlpf = vreg_reg[5'(R_CTRLPF)]; vid.refp0 = vreg_reg[5'(R_REFP0)];
        vid.refp1 = vreg_reg[5'(R_REFP1)]; vid.pf0 = vreg_reg[5'(R_PF0)];
        vid.pf1 = vreg_reg[5'(R_PF1)]; vid.pf2 = vreg_reg[5'(R_PF2)];
        vid.grp0 = vreg_reg[5'(R_GRP0)]; vid.grp1 = vreg_reg[5'(R_GRP1)];
        vid.enam0 = vreg_reg[5'(R_ENAM0)]; vid.enam1 = vreg_reg[5'(R_ENAM1)];
        vid.enabl = vreg_reg[5'(R_ENABL)];
        vid.pos_p0 = pp0_reg; vid.pos_p1 = pp1_reg; vid.pos_m0 = pm0_reg;
        vid.pos_m1 = pm1_reg; vid.pos_bl = pbl_reg;
    end

    sor_pixel u_pixel (.vid(vid), .x(xpos), .pix(pix));

    always_comb begin
        vreg_next = vreg_reg; hm_next = hm_reg; lat_next = lat_reg;
        dot_next = dot_reg; line_next = line_reg;
        pp0_next = pp0_reg; pp1_next = pp1_reg; pm0_next = pm0_reg;
        pm1_next = pm1_reg; pbl_next = pbl_reg;
        vbd_next = vbd_reg; ws_next = ws_reg;
        rd_next = 8'd0; pv_next = 1'b0; px_next = 8'd0; py_next = 8'd0;
        rgb_next = 24'd0; fr_next = 1'b0;
        unique case (s_cmd)
            CMD_WRITE: begin
                if (a < R_HMP0) vreg_next[a[4:0]] = s_wdata;
                else if (a <= R_HMBL) hm_next[a[2:0]] = s_wdata;
                else if (a >= R_CXM0P && a <= R_LAST_IN) lat_next[a[3:0]] = s_wdata;
                unique case (a)
                    R_VBLANK: if (vreg_reg[5'(R_VBLANK)][1] && !s_wdata[1]) begin
                        fr_next = 1'b1; vbd_next = 1'b1;
                    end
                    R_WSYNC: ws_next = 1'b1;
                    R_HMCLR: hm_next = '{default: 8'd0};
                    R_RESP0: pp0_next = (dot_reg < HBLANK_DOTS) ? 8'd3 : rpos;
                    R_RESP1: pp1_next = (dot_reg < HBLANK_DOTS) ? 8'd3 : rpos;
                    R_RESM0: pm0_next = (dot_reg < HBLANK_DOTS) ? 8'd2 : rpos;
                    R_RESM1: pm1_next = (dot_reg < HBLANK_DOTS) ? 8'd2 : rpos;
                    R_RESBL: pbl_next = (dot_reg < HBLANK_DOTS) ? 8'd2 : rpos;
                    R_HMOVE: begin
                        pm0_next = moved(pm0_reg, hm_reg[3'(R_HMM0)]);
                        pm1_next = moved(pm1_reg, hm_reg[3'(R_HMM1)]);
                        pp0_next = moved(pp0_reg, hm_reg[3'(R_HMP0)]);
                        pp1_next = moved(pp1_reg, hm_reg[3'(R_HMP1)]);
                        pbl_next = moved(pbl_reg, hm_reg[3'(R_HMBL)]);
                    end
                    R_CXCLR: for (int i = 0; i < 8; i++) lat_next[4'(i)] = 8'd0;
                    default: ;
                endcase
            end
            CMD_READ: begin
                if (s_addr < 16'h000E) rd_next = lat_reg[s_addr[3:0]];
                else if (s_addr >= 16'(R_CXM0P) && s_addr <= 16'(R_LAST_IN))
                    rd_next = lat_reg[s_addr[3:0]];
            end
            CMD_TICK: begin
                if (line_reg < VL && dot_reg >= HBLANK_DOTS && xpos < VISIBLE_DOTS) begin
                    pv_next = 1'b1; px_next = xpos; py_next = line_reg[7:0];
                    rgb_next = pix.rgb;
                    lat_next[4'(R_CXM0P)] = lat_reg[4'(R_CXM0P)] | {pix.hits[14:13], 6'd0};
                    lat_next[4'(R_CXM1P)] = lat_reg[4'(R_CXM1P)] | {pix.hits[12:11], 6'd0};
                    lat_next[4'(R_CXP0FB)] = lat_reg[4'(R_CXP0FB)] | {pix.hits[10:9], 6'd0};
                    lat_next[4'(R_CXP1FB)] = lat_reg[4'(R_CXP1FB)] | {pix.hits[8:7], 6'd0};
                    lat_next[4'(R_CXM0FB)] = lat_reg[4'(R_CXM0FB)] | {pix.hits[6:5], 6'd0};
                    lat_next[4'(R_CXM1FB)] = lat_reg[4'(R_CXM1FB)] | {pix.hits[4:3], 6'd0};
                    lat_next[4'(R_CXPPMM)] = lat_reg[4'(R_CXPPMM)] | {pix.hits[2:1], 6'd0};
                    lat_next[4'(R_CXBLPF)] = lat_reg[4'(R_CXBLPF)] | {pix.hits[0], 7'd0};
                end
                dot_next = dotp1;
                if (dotp1 == DPL) begin
                    if (vbd_reg) begin
                        line_next = 9'd0; vbd_next = 1'b0;
                    end else if (line_reg != 9'h1FF) begin
                        line_next = line_reg + 9'd1;
                    end
                    dot_next = 8'd0; ws_next = 1'b0;
                end
            end
            CMD_FIRE: lat_next[4'(R_INPT4)] = s_wdata;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vreg_reg <= '{default: 8'd0};
            hm_reg <= '{default: 8'd0};
            lat_reg <= '{default: 8'd0};
            dot_reg <= 8'd0; line_reg <= 9'd0;
            pp0_reg <= 8'd0; pp1_reg <= 8'd0; pm0_reg <= 8'd0;
            pm1_reg <= 8'd0; pbl_reg <= 8'd0;
            vbd_reg <= 1'b0; ws_reg <= 1'b0; mv_reg <= 1'b0;
        end else begin
            if (take) begin
                vreg_reg <= vreg_next; hm_reg <= hm_next; lat_reg <= lat_next;
                dot_reg <= dot_next; line_reg <= line_next;
                pp0_reg <= pp0_next; pp1_reg <= pp1_next; pm0_reg <= pm0_next;
                pm1_reg <= pm1_next; pbl_reg <= pbl_next;
                vbd_reg <= vbd_next; ws_reg <= ws_next;
            end
            if (take) mv_reg <= 1'b1;
            else if (m_ready) mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            rd_reg <= rd_next; pv_reg <= pv_next; px_reg <= px_next;
            py_reg <= py_next; rgb_reg <= rgb_next; fr_reg <= fr_next;
        end
    end

    assign m_valid = mv_reg;
    assign m_rdata = rd_reg;
    assign m_pixel_valid = pv_reg;
    assign m_pixel_x = px_reg;
    assign m_pixel_y = py_reg;
    assign m_pixel_rgb = rgb_reg;
    assign m_frame_ready = fr_reg;
    assign m_wsync_busy = ws_reg;

    `SOR_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_pixel_rgb))
    `SOR_ASSERT_IMP(a_stall, aclk, aresetn, m_valid && !m_ready, !s_ready)
    `SOR_ASSERT_IMP(a_pix, aclk, aresetn, m_valid && m_pixel_valid, m_pixel_x < VISIBLE_DOTS)
endmodule

[sim/sor_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sor_checker
// Watches both channels of the renderer, keeps its own model of the register
// store, counters and object positions, and compares every result.
// ----------------------------------------------------------------------------
module sor_checker import sor_pkg::*; #(
    parameter int DOTS_PER_LINE = 228,
    parameter int VISIBLE_LINES = 192
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [15:0] s_addr,
    input  logic [7:0]  s_wdata,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_rdata,
    input  logic        m_pixel_valid,
    input  logic [7:0]  m_pixel_x,
    input  logic [7:0]  m_pixel_y,
    input  logic [23:0] m_pixel_rgb,
    input  logic        m_frame_ready,
    input  logic        m_wsync_busy,
    output int          errors,
    output int          pending
);
    typedef struct packed {
        logic [7:0]  rdata;
        logic        pix_valid;
        logic [7:0]  pix_x;
        logic [7:0]  pix_y;
        logic [23:0] rgb;
        logic        frame;
        logic        wsync;
    } video_result_t;

    logic [7:0]    regs [256];
    int            dot_no, line_no;
    int            p0_pos, p1_pos, m0_pos, m1_pos, bl_pos;
    logic          frame_end_pending, wsync_held;
    video_result_t pixel_queue[$];

    assign pending = pixel_queue.size();

    function automatic logic pf_left(int q);
        if (q < 4) return regs[R_PF0][4 + q];
        if (q < 12) return regs[R_PF1][7 - (q - 4)];
        return regs[R_PF2][(q - 12) & 7];
    endfunction

    function automatic logic pf_at(int col);
        int q;
        if (col < 20) return pf_left(col);
        q = col - 20;
        if (!regs[R_CTRLPF][0]) return pf_left(q);
        if (q < 8) return regs[R_PF2][7 - q];
        if (q < 16) return regs[R_PF1][q - 8];
        return regs[R_PF0][7 - ((q - 16) & 3)];
    endfunction

    function automatic logic span_on(logic [7:0] en, logic [7:0] sz, int start, int x);
        int width;
        width = 1 << (sz[5:4]);
        return en[1] && x >= start && x - start < width;
    endfunction

    function automatic logic player_on(logic [7:0] gfx, logic [7:0] refl, int start, int x);
        int k;
        if (x < start || x - start >= 8) return 1'b0;
        k = x - start;
        if (refl[3]) k = k ^ 7;
        return gfx[7 ^ k];
    endfunction

    // Fine motion moves by minus the signed high nibble, wrapping on 160.
    function automatic int shifted(int pos, logic [7:0] hm);
        int nib;
        int v;
        nib = int'(hm[7:4]);
        if (nib >= 8) nib -= 16;
        v = pos - nib;
        if (v < 0) v += 160;
        if (v >= 160) v -= 160;
        return v & 8'hFF;
    endfunction

    function automatic int start_pos(int early);
        if (dot_no < HBLANK_DOTS) return early;
        return (dot_no - HBLANK_DOTS + 8) & 8'hFF;
    endfunction

    // Draws one pixel, latching collisions as a side effect.
    function automatic logic [23:0] draw_pixel(int x);
        logic pf, m0, m1, bl, p0, p1;
        logic [7:0] sel;
        pf = pf_at(x >> 2);
        m0 = span_on(regs[R_ENAM0], regs[R_NUSIZ0], m0_pos, x);
        m1 = span_on(regs[R_ENAM1], regs[R_NUSIZ1], m1_pos, x);
        bl = span_on(regs[R_ENABL], regs[R_CTRLPF], bl_pos, x);
        p0 = player_on(regs[R_GRP0], regs[R_REFP0], p0_pos, x);
        p1 = player_on(regs[R_GRP1], regs[R_REFP1], p1_pos, x);
        if (m0 && p1) regs[R_CXM0P][7] = 1'b1;
        if (m0 && p0) regs[R_CXM0P][6] = 1'b1;
        if (m1 && p0) regs[R_CXM1P][7] = 1'b1;
        if (m1 && p1) regs[R_CXM1P][6] = 1'b1;
        if (p0 && pf) regs[R_CXP0FB][7] = 1'b1;
        if (p0 && bl) regs[R_CXP0FB][6] = 1'b1;
        if (p1 && pf) regs[R_CXP1FB][7] = 1'b1;
        if (p1 && bl) regs[R_CXP1FB][6] = 1'b1;
        if (m0 && pf) regs[R_CXM0FB][7] = 1'b1;
        if (m0 && bl) regs[R_CXM0FB][6] = 1'b1;
        if (m1 && pf) regs[R_CXM1FB][7] = 1'b1;
        if (m1 && bl) regs[R_CXM1FB][6] = 1'b1;
        if (p0 && p1) regs[R_CXPPMM][7] = 1'b1;
        if (m0 && m1) regs[R_CXPPMM][6] = 1'b1;
        if (bl && pf) regs[R_CXBLPF][7] = 1'b1;
        if (regs[R_CTRLPF][2]) begin
            if (pf || bl) sel = R_COLUPF;
            else if (p0 || m0) sel = R_COLUP0;
            else if (p1 || m1) sel = R_COLUP1;
            else sel = R_COLUBK;
        end else begin
            if (p0 || m0) sel = R_COLUP0;
            else if (p1 || m1) sel = R_COLUP1;
            else if (pf || bl) sel = R_COLUPF;
            else sel = R_COLUBK;
        end
        return COLOR_ROM[regs[sel][7:1]];
    endfunction

    function automatic video_result_t run_command(logic [1:0] cmd, logic [15:0] addr,
                                                  logic [7:0] wd);
        video_result_t r;
        logic [7:0] a, old;
        r = '0;
        a = addr[7:0];
        case (cmd)
            CMD_WRITE: begin
                old = regs[a];
                regs[a] = wd;
                case (a)
                    R_VBLANK: if (old[1] && !wd[1]) begin
                        r.frame = 1'b1;
                        frame_end_pending = 1'b1;
                    end
                    R_WSYNC: wsync_held = 1'b1;
                    R_HMCLR: for (int i = R_HMP0; i <= R_HMBL; i++) regs[i] = '0;
                    R_RESP0: p0_pos = start_pos(3);
                    R_RESP1: p1_pos = start_pos(3);
                    R_RESM0: m0_pos = start_pos(2);
                    R_RESM1: m1_pos = start_pos(2);
                    R_RESBL: bl_pos = start_pos(2);
                    R_HMOVE: begin
                        m0_pos = shifted(m0_pos, regs[R_HMM0]);
                        m1_pos = shifted(m1_pos, regs[R_HMM1]);
                        p0_pos = shifted(p0_pos, regs[R_HMP0]);
                        p1_pos = shifted(p1_pos, regs[R_HMP1]);
                        bl_pos = shifted(bl_pos, regs[R_HMBL]);
                    end
                    R_CXCLR: for (int i = R_CXM0P; i <= R_CXPPMM; i++) regs[i] = '0;
                    default: ;
                endcase
            end
            CMD_READ: begin
                // Low addresses mirror the collision and input latches.
                if (addr < 16'h000E) r.rdata = regs[addr[7:0] + 8'h30];
                else if (addr >= R_CXM0P && addr <= R_LAST_IN) r.rdata = regs[addr[7:0]];
            end
            CMD_TICK: begin
                if (line_no < VISIBLE_LINES && dot_no >= HBLANK_DOTS &&
                    dot_no - HBLANK_DOTS < VISIBLE_DOTS) begin
                    r.pix_x = 8'(dot_no - HBLANK_DOTS);
                    r.pix_y = line_no[7:0];
                    r.rgb = draw_pixel(dot_no - HBLANK_DOTS);
                    r.pix_valid = 1'b1;
                end
                dot_no = (dot_no + 1) & 8'hFF;
                if (dot_no == DOTS_PER_LINE) begin
                    if (frame_end_pending) begin
                        line_no = 0;
                        frame_end_pending = 1'b0;
                    end else if (line_no < 511) begin
                        line_no++;
                    end
                    dot_no = 0;
                    wsync_held = 1'b0;
                end
            end
            default: regs[R_INPT4] = wd;
        endcase
        r.wsync = wsync_held;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge aclk) begin
        video_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < 256; i++) regs[i] = '0;
            dot_no = 0;
            line_no = 0;
            p0_pos = 0; p1_pos = 0; m0_pos = 0; m1_pos = 0; bl_pos = 0;
            frame_end_pending = 1'b0;
            wsync_held = 1'b0;
            pixel_queue.delete();
        end else begin
            // Results are checked before the new command is modelled; as each result is
            // registered, a result never belongs to the same edge's input.
            if (m_valid && m_ready) begin
                if (pixel_queue.size() == 0) begin
                    report_mismatch("results outstanding", 1, 0);
                end else begin
                    want = pixel_queue.pop_front();
                    if (m_rdata !== want.rdata) report_mismatch("rdata", m_rdata, want.rdata);
                    if (m_pixel_valid !== want.pix_valid)
                        report_mismatch("pixel_valid", m_pixel_valid, want.pix_valid);
                    if (m_pixel_x !== want.pix_x) report_mismatch("pixel_x", m_pixel_x, want.pix_x);
                    if (m_pixel_y !== want.pix_y) report_mismatch("pixel_y", m_pixel_y, want.pix_y);
                    if (m_pixel_rgb !== want.rgb) report_mismatch("pixel_rgb", m_pixel_rgb, want.rgb);
                    if (m_frame_ready !== want.frame)
                        report_mismatch("frame_ready", m_frame_ready, want.frame);
                    if (m_wsync_busy !== want.wsync)
                        report_mismatch("wsync_busy", m_wsync_busy, want.wsync);
                end
            end
            if (s_valid && s_ready)
                pixel_queue.push_back(run_command(s_cmd, s_addr, s_wdata));
        end
    end
endmodule

[sim/tb_scanline_object_renderer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scanline_object_renderer
// Drives bus writes, reads, dot ticks and fire button commands into the
// renderer under varying back-pressure; a checker beside it compares results.
// ----------------------------------------------------------------------------
module tb_scanline_object_renderer;
    import sor_pkg::*;

    // Cycles without any transaction before the run is declared hung. The
    // longest deliberate stall is the receiver hold-off below.
    localparam int HANG_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_cmd;
    logic [15:0] s_addr;
    logic [7:0]  s_wdata;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_rdata;
    logic        m_pixel_valid;
    logic [7:0]  m_pixel_x;
    logic [7:0]  m_pixel_y;
    logic [23:0] m_pixel_rgb;
    logic        m_frame_ready;
    logic        m_wsync_busy;
    int          errors;
    int          pending;

    // Idle percentages for the sender and the receiver; changed per phase.
    int          tx_idle_pct;
    int          rx_idle_pct;
    logic        hold_request;
    int          quiet_cycles;

    scanline_object_renderer dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_cmd, .s_addr, .s_wdata,
        .m_valid, .m_ready, .m_rdata, .m_pixel_valid, .m_pixel_x, .m_pixel_y,
        .m_pixel_rgb, .m_frame_ready, .m_wsync_busy
    );

    sor_checker u_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_cmd, .s_addr, .s_wdata,
        .m_valid, .m_ready, .m_rdata, .m_pixel_valid, .m_pixel_x, .m_pixel_y,
        .m_pixel_rgb, .m_frame_ready, .m_wsync_busy, .errors, .pending
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Receiver: random stalls, plus one long hold-off on request so that the
    // output register fills and the block has to stall its input side.
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                m_ready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: a long stretch with no transaction on either side means the
    // block has hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one command and holds it until the transaction completes. Any
    // idle gap comes first, so valid is never dropped within an offer.
    task automatic issue(input logic [1:0] cmd, input logic [15:0] addr,
                         input logic [7:0] wdata);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_cmd = cmd;
        s_addr = addr;
        s_wdata = wdata;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // A random command. Dot ticks dominate so that the counters sweep the
    // visible area; writes mostly target the mapped registers, but any low
    // byte is possible, and the upper address byte is always random.
    task automatic issue_random();
        int pick;
        logic [7:0] low;
        pick = $urandom_range(99);
        if (pick < 55) begin
            issue(CMD_TICK, 16'($urandom), 8'($urandom));
        end else if (pick < 85) begin
            low = ($urandom_range(9) < 8) ? 8'($urandom_range(8'h3F)) : 8'($urandom);
            issue(CMD_WRITE, {8'($urandom), low}, 8'($urandom));
        end else if (pick < 95) begin
            case ($urandom_range(2))
                0: issue(CMD_READ, 16'($urandom_range(16'h000D)), 8'($urandom));
                1: issue(CMD_READ, 16'($urandom_range(16'h003F)), 8'($urandom));
                default: issue(CMD_READ, 16'($urandom), 8'($urandom));
            endcase
        end else begin
            issue(CMD_FIRE, 16'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = CMD_WRITE;
        s_addr = '0;
        s_wdata = '0;
        tx_idle_pct = 19;
        rx_idle_pct = 47;
        hold_request = 1'b0;
        quiet_cycles = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed scene: mirrored playfield with priority, a reflected
        // player, a wide missile and the ball, then motion and the latches.
        issue(CMD_WRITE, {8'h00, R_PF0}, 8'hF0);
        issue(CMD_WRITE, {8'h00, R_PF1}, 8'hAA);
        issue(CMD_WRITE, {8'h00, R_PF2}, 8'h55);
        issue(CMD_WRITE, {8'hFF, R_CTRLPF}, 8'h35);
        issue(CMD_WRITE, {8'h00, R_COLUP0}, 8'hFF);
        issue(CMD_WRITE, {8'h00, R_COLUPF}, 8'h1E);
        issue(CMD_WRITE, {8'h00, R_GRP0}, 8'hC3);
        issue(CMD_WRITE, {8'h00, R_REFP0}, 8'h08);
        issue(CMD_WRITE, {8'h00, R_NUSIZ0}, 8'h30);
        issue(CMD_WRITE, {8'h00, R_ENAM0}, 8'h02);
        issue(CMD_WRITE, {8'h00, R_ENABL}, 8'hFF);
        // Position reset during horizontal blank takes the early position.
        issue(CMD_WRITE, {8'h00, R_RESP0}, 8'h00);
        issue(CMD_WRITE, {8'h00, R_HMP0}, 8'h70);
        issue(CMD_WRITE, {8'h00, R_HMM0}, 8'h80);
        issue(CMD_WRITE, {8'h00, R_HMOVE}, 8'h00);
        issue(CMD_WRITE, {8'h00, R_HMCLR}, 8'h00);
        issue(CMD_FIRE, 16'hFFFF, 8'hFF);
        issue(CMD_READ, 16'h000C, 8'h00);
        issue(CMD_READ, {8'h00, R_INPT4}, 8'h00);
        issue(CMD_READ, 16'hFFFF, 8'h00);
        issue(CMD_READ, 16'h003E, 8'h00);
        issue(CMD_WRITE, {8'h00, R_WSYNC}, 8'h00);
        issue(CMD_WRITE, {8'h00, R_VBLANK}, 8'h02);
        issue(CMD_WRITE, {8'h00, R_VBLANK}, 8'h00);
        issue(CMD_FIRE, 16'h0000, 8'h00);

        // Three random phases with the idling swapped, then none.
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 47 : 0;
            rx_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 19 : 0;
            if (phase == 2) hold_request = 1'b1;
            repeat (235) issue_random();
        end

        // A few ticks between two position resets wherever the line now is,
        // then a vblank fall that restarts the frame at the next line end.
        issue(CMD_WRITE, {8'h00, R_RESBL}, 8'h00);
        repeat (12) issue(CMD_TICK, 16'($urandom), 8'($urandom));
        issue(CMD_WRITE, {8'h00, R_RESP1}, 8'h00);
        issue(CMD_WRITE, {8'h00, R_VBLANK}, 8'h02);
        issue(CMD_WRITE, {8'h00, R_VBLANK}, 8'h00);

        s_valid = 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

[scanline_object_renderer.f]
+incdir+rtl
rtl/sor_pkg.sv
rtl/sor_pixel.sv
rtl/scanline_object_renderer.sv
sim/sor_checker.sv
sim/tb_scanline_object_renderer.sv
